// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the volume pattern density generator.
// Each macro expects aclk and aresetn to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define VPDG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same, for a property that holds in the cycle after its trigger.
`define VPDG_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/vpdg_pkg.sv =====
// Package for the volume pattern density generator: register indexes, waveform
// modes, fixed-point constants and the sine and exponential tables. No dependencies.
package vpdg_pkg;

    localparam int CoordW   = 12;
    localparam int MagW     = 16;
    localparam int FreqW    = 8;
    localparam int ModeW    = 3;
    localparam int DensW    = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam int ResDefault = 256;

    // 2^32 / pi^2, rounded: one radian of c*freq*(2/pi)/res in 2^-32 turns.
    localparam longint unsigned TurnK = 64'd435171170;

    localparam logic [14:0] OneQ14 = 15'd16384;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE   = 3'd0,
        CFG_MAG_X  = 3'd1,
        CFG_MAG_Y  = 3'd2,
        CFG_MAG_Z  = 3'd3,
        CFG_FREQ_X = 3'd4,
        CFG_FREQ_Y = 3'd5,
        CFG_FREQ_Z = 3'd6
    } cfg_index_t;

    typedef enum logic [ModeW-1:0] {
        MODE_RECT     = 3'd0,
        MODE_TRIANGLE = 3'd1,
        MODE_SINE     = 3'd2,
        MODE_SINE_SQ  = 3'd3,
        MODE_SINE_EXP = 3'd4,
        MODE_COS      = 3'd5,
        MODE_COS_SQ   = 3'd6,
        MODE_COS_EXP  = 3'd7
    } wave_mode_t;

    // Quarter-wave sine, Q1.14, at steps of 1/64 turn.
    function automatic logic [14:0] sin_tab(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd1606;
            5'd2:    v = 15'd3196;
            5'd3:    v = 15'd4756;
            5'd4:    v = 15'd6270;
            5'd5:    v = 15'd7723;
            5'd6:    v = 15'd9102;
            5'd7:    v = 15'd10394;
            5'd8:    v = 15'd11585;
            5'd9:    v = 15'd12665;
            5'd10:   v = 15'd13623;
            5'd11:   v = 15'd14449;
            5'd12:   v = 15'd15137;
            5'd13:   v = 15'd15679;
            5'd14:   v = 15'd16069;
            5'd15:   v = 15'd16305;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // exp(-2 + k/8), Q1.14.
    function automatic logic [14:0] exp_tab(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0:    v = 15'd2217;
            5'd1:    v = 15'd2513;
            5'd2:    v = 15'd2847;
            5'd3:    v = 15'd3226;
            5'd4:    v = 15'd3656;
            5'd5:    v = 15'd4143;
            5'd6:    v = 15'd4694;
            5'd7:    v = 15'd5319;
            5'd8:    v = 15'd6027;
            5'd9:    v = 15'd6830;
            5'd10:   v = 15'd7739;
            5'd11:   v = 15'd8770;
            5'd12:   v = 15'd9937;
            5'd13:   v = 15'd11261;
            5'd14:   v = 15'd12760;
            5'd15:   v = 15'd14459;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/volume_pattern_density_generator.sv =====
// Volume pattern density generator: a 15-stage pipeline turning a voxel coordinate
// into a Q2.14 density. Depends on vpdg_pkg and assert_macros.svh.
// Throughput: one transaction per cycle unless the output or normalizer stalls;
// per-stage valid bits let bubbles collapse behind a stalled output.
// A magnitude write starts a shared restoring divider that normalizes the
// magnitudes; s_ready stays low meanwhile. Reset (aresetn, sync, active low)
// clears the registers to mode rect, magnitudes 0, frequencies 1.
`include "assert_macros.svh"

module volume_pattern_density_generator #(
    parameter int RES_X = vpdg_pkg::ResDefault,
    parameter int RES_Y = vpdg_pkg::ResDefault,
    parameter int RES_Z = vpdg_pkg::ResDefault
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [vpdg_pkg::CoordW-1:0]    s_coord_x,
    input  logic [vpdg_pkg::CoordW-1:0]    s_coord_y,
    input  logic [vpdg_pkg::CoordW-1:0]    s_coord_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [vpdg_pkg::DensW-1:0] m_density,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vpdg_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vpdg_pkg::CfgDataW-1:0]  cfg_data
);
    import vpdg_pkg::*;

    localparam int NumStages = 15;

    // floor(c*f*K/R) = c*f*A + floor(c*f*B/R); the last term uses a reciprocal.
    localparam logic [28:0] TURN_A_X = 29'(TurnK / RES_X);
    localparam logic [28:0] TURN_A_Y = 29'(TurnK / RES_Y);
    localparam logic [28:0] TURN_A_Z = 29'(TurnK / RES_Z);
    localparam logic [11:0] TURN_B_X = 12'(TurnK % RES_X);
    localparam logic [11:0] TURN_B_Y = 12'(TurnK % RES_Y);
    localparam logic [11:0] TURN_B_Z = 12'(TurnK % RES_Z);
    localparam logic [32:0] RECIP_X  = 33'((64'd1 << 32) / RES_X);
    localparam logic [32:0] RECIP_Y  = 33'((64'd1 << 32) / RES_Y);
    localparam logic [32:0] RECIP_Z  = 33'((64'd1 << 32) / RES_Z);

    localparam logic [28:0] TurnA [3] = '{TURN_A_X, TURN_A_Y, TURN_A_Z};
    localparam logic [11:0] TurnB [3] = '{TURN_B_X, TURN_B_Y, TURN_B_Z};
    localparam logic [32:0] Recip [3] = '{RECIP_X, RECIP_Y, RECIP_Z};
    localparam logic [12:0] ResV  [3] = '{13'(RES_X), 13'(RES_Y), 13'(RES_Z)};

    // ---------------------------------------------------------------- config
    logic [ModeW-1:0] mode_reg;
    logic [MagW-1:0]  mag_reg  [3];
    logic [FreqW-1:0] freq_reg [3];
    logic             cfg_wr;
    logic             mag_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign mag_wr    = cfg_wr && (cfg_index == CFG_MAG_X || cfg_index == CFG_MAG_Y ||
                                  cfg_index == CFG_MAG_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RECT;
            for (int a = 0; a < 3; a++) begin
                mag_reg[a]  <= '0;
                freq_reg[a] <= FreqW'(1);
            end
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_MODE:   mode_reg    <= cfg_data[ModeW-1:0];
                CFG_MAG_X:  mag_reg[0]  <= cfg_data[MagW-1:0];
                CFG_MAG_Y:  mag_reg[1]  <= cfg_data[MagW-1:0];
                CFG_MAG_Z:  mag_reg[2]  <= cfg_data[MagW-1:0];
                CFG_FREQ_X: freq_reg[0] <= cfg_data[FreqW-1:0];
                CFG_FREQ_Y: freq_reg[1] <= cfg_data[FreqW-1:0];
                CFG_FREQ_Z: freq_reg[2] <= cfg_data[FreqW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------- magnitude normalizer
    typedef enum logic [1:0] {NRM_IDLE, NRM_LOAD, NRM_ITER} nrm_state_t;

    nrm_state_t  nrm_state_reg;
    logic [1:0]  axis_reg;
    logic [3:0]  cnt_reg;
    logic [17:0] rem_reg;
    logic [13:0] quo_reg;
    logic [14:0] mn_reg [3];

    logic [17:0] mag_sum;
    logic        need_norm;
    logic        div_bit;
    logic [18:0] div_shift;
    logic        div_ge;
    logic [17:0] rem_next;

    assign mag_sum   = 18'(mag_reg[0]) + 18'(mag_reg[1]) + 18'(mag_reg[2]);
    assign need_norm = mag_sum > 18'(OneQ14);
    assign div_bit   = (cnt_reg == 4'd0) ? mag_reg[axis_reg][0] : 1'b0;
    assign div_shift = {rem_reg, div_bit};
    assign div_ge    = div_shift >= {1'b0, mag_sum};
    assign rem_next  = div_ge ? 18'(div_shift - {1'b0, mag_sum}) : div_shift[17:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrm_state_reg <= NRM_IDLE;
            axis_reg      <= '0;
            cnt_reg       <= '0;
            for (int a = 0; a < 3; a++) mn_reg[a] <= '0;
        end else if (mag_wr) begin
            nrm_state_reg <= NRM_LOAD;
            axis_reg      <= '0;
        end else begin
            case (nrm_state_reg)
                NRM_LOAD: begin
                    if (!need_norm) begin
                        for (int a = 0; a < 3; a++) mn_reg[a] <= mag_reg[a][14:0];
                        nrm_state_reg <= NRM_IDLE;
                    end else begin
                        rem_reg       <= 18'(mag_reg[axis_reg] >> 1);
                        cnt_reg       <= '0;
                        nrm_state_reg <= NRM_ITER;
                    end
                end
                NRM_ITER: begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[12:0], div_ge};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd14) begin
                        mn_reg[axis_reg] <= {quo_reg, div_ge};
                        if (axis_reg == 2'd2) begin
                            nrm_state_reg <= NRM_IDLE;
                        end else begin
                            axis_reg      <= axis_reg + 2'd1;
                            nrm_state_reg <= NRM_LOAD;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- flow control
    logic [NumStages:1] v_reg;
    logic [NumStages:1] en;
    logic               in_fire;

    always_comb begin
        en[NumStages] = !v_reg[NumStages] || m_ready;
        for (int i = NumStages - 1; i >= 1; i--) en[i] = !v_reg[i] || en[i+1];
    end

    assign s_ready = en[1] && (nrm_state_reg == NRM_IDLE);
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= in_fire;
            for (int i = 2; i <= NumStages; i++)
                if (en[i]) v_reg[i] <= v_reg[i-1];
        end
    end

    logic cos_mode;
    assign cos_mode = (mode_reg == MODE_COS) || (mode_reg == MODE_COS_SQ) ||
                      (mode_reg == MODE_COS_EXP);

    // ---------------------------------------------------------- datapath
    logic [CoordW-1:0] coord [3];
    assign coord[0] = s_coord_x;
    assign coord[1] = s_coord_y;
    assign coord[2] = s_coord_z;

    logic [19:0] cf1_reg  [3];
    logic [2:0]  k_reg    [3:12][3];
    logic [31:0] pa2_reg  [3];
    logic [31:0] y2_reg   [3];
    logic [31:0] pa3_reg  [3];
    logic [31:0] y3_reg   [3];
    logic [48:0] ph3_reg  [3];
    logic [48:0] pl3_reg  [3];
    logic [31:0] pa4_reg  [3];
    logic [31:0] y4_reg   [3];
    logic [31:0] q04_reg  [3];
    logic [31:0] pa5_reg  [3];
    logic [31:0] y5_reg   [3];
    logic [31:0] q05_reg  [3];
    logic [31:0] qr5_reg  [3];
    logic [31:0] qt6_reg  [3];
    logic [15:0] turn7_reg [3];
    logic [14:0] base8_reg [3];
    logic [14:0] diff8_reg [3];
    logic [9:0]  frac8_reg [3];
    logic        neg8_reg  [3];
    logic signed [15:0] s9_reg [3];
    logic signed [15:0] s10_reg [3];
    logic [14:0] sq10_reg  [3];
    logic [14:0] eb10_reg  [3];
    logic [14:0] ed10_reg  [3];
    logic [10:0] ef10_reg  [3];
    logic signed [15:0] w11_reg [3];
    logic signed [30:0] p12_reg [3];
    logic signed [31:0] sum13_reg;
    logic [35:0]        tri14_reg;
    logic signed [17:0] sh14_reg;
    logic signed [DensW-1:0] dens_reg;

    logic [23:0] m6    [3];
    logic [9:0]  q6    [3];
    logic [64:0] rsum  [3];
    logic [31:0] rdiff [3];
    logic [31:0] qfix  [3];
    logic [13:0] tr    [3];
    logic [14:0] rr    [3];
    logic [4:0]  sidx  [3];
    logic [14:0] sbase [3];
    logic [14:0] snext [3];
    logic [24:0] sprod [3];
    logic [14:0] sv    [3];
    logic signed [31:0] ssq [3];
    logic [15:0] u     [3];
    logic [4:0]  eidx  [3];
    logic [14:0] ebase [3];
    logic [14:0] enext [3];
    logic [25:0] eprod [3];
    logic [14:0] ev    [3];
    logic [15:0] wtrig [3];
    logic [2:0]  tri_t [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // c mod 6 through a reciprocal; exact for 12-bit coordinates.
            m6[a]    = 24'(coord[a]) * 24'd2731;
            q6[a]    = m6[a][23:14];
            rsum[a]  = {ph3_reg[a], 16'b0} + 65'(pl3_reg[a]);
            rdiff[a] = y5_reg[a] - qr5_reg[a];
            qfix[a]  = (rdiff[a] >= 32'(ResV[a])) ? q05_reg[a] + 32'd1 : q05_reg[a];
            tr[a]    = turn7_reg[a][13:0];
            rr[a]    = turn7_reg[a][14] ? 15'(OneQ14 - 15'(tr[a])) : {1'b0, tr[a]};
            sidx[a]  = rr[a][14:10];
            sbase[a] = sin_tab(sidx[a]);
            snext[a] = (sidx[a] >= 5'd16) ? sbase[a] : sin_tab(5'(sidx[a] + 5'd1));
            sprod[a] = 25'(diff8_reg[a]) * 25'(frac8_reg[a]);
            sv[a]    = base8_reg[a] + 15'(sprod[a] >> 10);
            ssq[a]   = s9_reg[a] * s9_reg[a];
            u[a]     = 16'(s9_reg[a] + 16'sd16384);
            eidx[a]  = u[a][15:11];
            ebase[a] = exp_tab(eidx[a]);
            enext[a] = (eidx[a] >= 5'd16) ? ebase[a] : exp_tab(5'(eidx[a] + 5'd1));
            eprod[a] = 26'(ed10_reg[a]) * 26'(ef10_reg[a]);
            ev[a]    = eb10_reg[a] + 15'(eprod[a] >> 11);
            tri_t[a] = (k_reg[12][a] >= 3'd3) ? k_reg[12][a] - 3'd3 : 3'd3 - k_reg[12][a];
            case (mode_reg)
                MODE_SINE_SQ, MODE_COS_SQ:
                    wtrig[a] = 16'((17'(sq10_reg[a]) + 17'(OneQ14)) >> 1);
                MODE_SINE_EXP, MODE_COS_EXP:
                    wtrig[a] = 16'((17'(ev[a]) + 17'(OneQ14)) >> 1);
                default:
                    wtrig[a] = 16'(17'(s10_reg[a] + 16'sd16384) >> 1);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            if (en[1]) begin
                cf1_reg[a]  <= 20'(coord[a]) * 20'(freq_reg[a]);
                k_reg[3][a] <= 3'(coord[a] - 12'(q6[a]) * 12'd6);
            end
            if (en[2]) begin
                pa2_reg[a]  <= 32'(49'(cf1_reg[a]) * 49'(TurnA[a]));
                y2_reg[a]   <= 32'(cf1_reg[a]) * 32'(TurnB[a]);
                k_reg[4][a] <= k_reg[3][a];
            end
            if (en[3]) begin
                ph3_reg[a]  <= 49'(y2_reg[a][31:16]) * 49'(Recip[a]);
                pl3_reg[a]  <= 49'(y2_reg[a][15:0]) * 49'(Recip[a]);
                y3_reg[a]   <= y2_reg[a];
                pa3_reg[a]  <= pa2_reg[a];
                k_reg[5][a] <= k_reg[4][a];
            end
            if (en[4]) begin
                q04_reg[a]  <= rsum[a][63:32];
                y4_reg[a]   <= y3_reg[a];
                pa4_reg[a]  <= pa3_reg[a];
                k_reg[6][a] <= k_reg[5][a];
            end
            if (en[5]) begin
                qr5_reg[a]  <= 32'(45'(q04_reg[a]) * 45'(ResV[a]));
                q05_reg[a]  <= q04_reg[a];
                y5_reg[a]   <= y4_reg[a];
                pa5_reg[a]  <= pa4_reg[a];
                k_reg[7][a] <= k_reg[6][a];
            end
            if (en[6]) begin
                qt6_reg[a]  <= pa5_reg[a] + qfix[a];
                k_reg[8][a] <= k_reg[7][a];
            end
            if (en[7]) begin
                // Cosine is the sine a quarter turn ahead.
                turn7_reg[a] <= qt6_reg[a][31:16] + (cos_mode ? 16'(OneQ14) : 16'd0);
                k_reg[9][a]  <= k_reg[8][a];
            end
            if (en[8]) begin
                base8_reg[a] <= sbase[a];
                diff8_reg[a] <= snext[a] - sbase[a];
                frac8_reg[a] <= rr[a][9:0];
                neg8_reg[a]  <= turn7_reg[a][15];
                k_reg[10][a] <= k_reg[9][a];
            end
            if (en[9]) begin
                s9_reg[a]    <= neg8_reg[a] ? -$signed({1'b0, sv[a]}) : $signed({1'b0, sv[a]});
                k_reg[11][a] <= k_reg[10][a];
            end
            if (en[10]) begin
                s10_reg[a]   <= s9_reg[a];
                sq10_reg[a]  <= 15'(ssq[a][31:14]);
                eb10_reg[a]  <= ebase[a];
                ed10_reg[a]  <= enext[a] - ebase[a];
                ef10_reg[a]  <= u[a][10:0];
                k_reg[12][a] <= k_reg[11][a];
            end
            if (en[11]) begin
                case (mode_reg)
                    MODE_RECT:
                        w11_reg[a] <= (k_reg[12][a] < 3'd3) ? 16'sd16384 : -16'sd16384;
                    MODE_TRIANGLE:
                        w11_reg[a] <= $signed(16'(tri_t[a]));
                    default:
                        w11_reg[a] <= $signed(wtrig[a]);
                endcase
            end
            if (en[12]) begin
                p12_reg[a] <= 31'($signed({1'b0, mn_reg[a]}) * w11_reg[a]);
            end
        end
        if (en[13]) begin
            sum13_reg <= 32'(p12_reg[0]) + 32'(p12_reg[1]) + 32'(p12_reg[2]);
        end
        if (en[14]) begin
            // floor(x/3) as x*174763 >> 19; exact for the triangle range.
            tri14_reg <= 36'(sum13_reg[17:0]) * 36'd174763;
            sh14_reg  <= 18'(sum13_reg >>> 14);
        end
    end

    logic signed [17:0] pre_sat;
    assign pre_sat = (mode_reg == MODE_TRIANGLE) ? $signed({1'b0, tri14_reg[35:19]}) : sh14_reg;

    always_ff @(posedge aclk) begin
        if (en[15]) begin
            if (pre_sat > 18'sd32767)       dens_reg <= 16'sh7FFF;
            else if (pre_sat < -18'sd32768) dens_reg <= -16'sh8000;
            else                            dens_reg <= 16'(pre_sat);
        end
    end

    assign m_valid   = v_reg[NumStages];
    assign m_density = dens_reg;

    // ---------------------------------------------------------- assertions
    `VPDG_ASSERT(a_norm_blocks_input, (nrm_state_reg != NRM_IDLE) |-> !s_ready, "input taken during normalization")
    `VPDG_ASSERT_NEXT(a_mag_write_renorm, mag_wr, nrm_state_reg == NRM_LOAD, "magnitude write did not restart normalization")
    `VPDG_ASSERT(a_out_from_last_stage, $rose(m_valid) |-> $past(v_reg[NumStages-1]), "result appeared without an item in flight")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for volume_pattern_density_generator: random and directed
// voxels under many register settings, checked against a predictor. Needs vpdg_pkg.
`timescale 1ns / 100ps

module testbench;
    import vpdg_pkg::*;

    localparam int RES_AXIS = 256;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;
    localparam int NUM_PHASES = 24;

    localparam int SINE_QTR[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394,
        11585, 12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};
    localparam int EXP_CURVE[17] = '{2217, 2513, 2847, 3226, 3656, 4143, 4694, 5319,
        6027, 6830, 7739, 8770, 9937, 11261, 12760, 14459, 16384};

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] z;
    } voxel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CoordW-1:0] s_coord_x = '0;
    logic [CoordW-1:0] s_coord_y = '0;
    logic [CoordW-1:0] s_coord_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DensW-1:0] m_density;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // Register mirror, updated at each configuration transaction.
    wave_mode_t shape_mode = MODE_RECT;
    logic [MagW-1:0] axis_mag[3] = '{16'd0, 16'd0, 16'd0};
    logic [FreqW-1:0] axis_freq[3] = '{8'd1, 8'd1, 8'd1};

    voxel_t voxel_q[$];
    logic signed [DensW-1:0] density_q[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic stall_start = 1'b0;
    logic stall_on = 1'b0;
    int errors = 0;
    int cycles = 0;

    volume_pattern_density_generator uut (.*);

    always #5 aclk = ~aclk;

    function automatic int turn_sine(logic [15:0] t);
        int r, idx, fr, v;
        r = t[13:0];
        if (t[14]) r = 16384 - r;
        idx = r >> 10;
        fr = r & 1023;
        if (idx >= 16) v = 16384;
        else v = SINE_QTR[idx] + (((SINE_QTR[idx+1] - SINE_QTR[idx]) * fr) >> 10);
        return t[15] ? -v : v;
    endfunction

    function automatic int axis_wave(wave_mode_t md, logic [CoordW-1:0] c,
                                     logic [FreqW-1:0] f);
        longint unsigned prod;
        logic [15:0] turn;
        int s, u, idx, fr, e;
        prod = 64'(c) * 64'(f) * TurnK;
        turn = 16'((prod / RES_AXIS) >> 16);
        if (md >= MODE_COS) turn = turn + 16'd16384;
        s = turn_sine(turn);
        case (md)
            MODE_SINE_SQ, MODE_COS_SQ: return (((s * s) >> 14) + 16384) >> 1;
            MODE_SINE_EXP, MODE_COS_EXP: begin
                u = s + 16384;
                idx = u >> 11;
                fr = u & 2047;
                if (idx >= 16) e = 16384;
                else e = EXP_CURVE[idx] + (((EXP_CURVE[idx+1] - EXP_CURVE[idx]) * fr) >> 11);
                return (e + 16384) >> 1;
            end
            default: return (s + 16384) >> 1;
        endcase
    endfunction

    function automatic logic signed [DensW-1:0] voxel_density(voxel_t v);
        longint m[3];
        int c[3];
        longint sum, acc, dens;
        int k;
        c[0] = v.x; c[1] = v.y; c[2] = v.z;
        for (int i = 0; i < 3; i++) m[i] = axis_mag[i];
        sum = m[0] + m[1] + m[2];
        if (sum > 16384)
            for (int i = 0; i < 3; i++) m[i] = (m[i] * 16384) / sum;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            k = c[i] % 6;
            case (shape_mode)
                MODE_RECT: acc += (k < 3) ? m[i] : -m[i];
                MODE_TRIANGLE: acc += m[i] * ((k >= 3) ? k - 3 : 3 - k);
                default: acc += m[i] * axis_wave(shape_mode, c[i][CoordW-1:0], axis_freq[i]);
            endcase
        end
        if (shape_mode == MODE_RECT) dens = acc;
        else if (shape_mode == MODE_TRIANGLE) dens = acc / 3;
        else dens = acc >>> 14;
        if (dens > 32767) dens = 32767;
        if (dens < -32768) dens = -32768;
        return dens[DensW-1:0];
    endfunction

    // Input driver: a new voxel is offered only when the port slot is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                density_q.push_back(voxel_density(voxel_q.pop_front()));
            if (!s_valid || s_ready) begin
                if (voxel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_coord_x <= voxel_q[0].x;
                    s_coord_y <= voxel_q[0].y;
                    s_coord_z <= voxel_q[0].z;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (density_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected density %0d with nothing pending", m_density);
                end else if (m_density !== density_q[0]) begin
                    errors++;
                    if (errors <= 10)
                        $display("Density mismatch: expected %0d, got %0d",
                                 density_q[0], m_density);
                    void'(density_q.pop_front());
                end else begin
                    void'(density_q.pop_front());
                end
            end
            if (stall_on) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering transactions.
    initial begin
        wait (stall_start);
        @(posedge aclk);
        stall_on <= 1'b1;
        repeat (300) @(posedge aclk);
        stall_on <= 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("volume_pattern_density_generator: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MODE: shape_mode = wave_mode_t'(data[ModeW-1:0]);
            CFG_MAG_X: axis_mag[0] = data;
            CFG_MAG_Y: axis_mag[1] = data;
            CFG_MAG_Z: axis_mag[2] = data;
            CFG_FREQ_X: axis_freq[0] = data[FreqW-1:0];
            CFG_FREQ_Y: axis_freq[1] = data[FreqW-1:0];
            CFG_FREQ_Z: axis_freq[2] = data[FreqW-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (voxel_q.size() > 0 || density_q.size() > 0) @(posedge aclk);
    endtask

    initial begin
        logic [MagW-1:0] mag[3];
        logic [FreqW-1:0] freq[3];
        voxel_t v;
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values first: rect mode with all magnitudes zero.
        voxel_q.push_back('{12'd0, 12'd4095, 12'd3});
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 5)
                0: mag = '{16'd0, 16'd0, 16'd0};
                1: mag = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: for (int i = 0; i < 3; i++) mag[i] = 16'($urandom_range(5461));
                3: for (int i = 0; i < 3; i++) mag[i] = 16'($urandom);
                default: mag = '{16'd16384, 16'd0, 16'(p & 1)};
            endcase
            for (int i = 0; i < 3; i++)
                case (p % 3)
                    0: freq[i] = (p < 8) ? 8'd0 : 8'($urandom);
                    1: freq[i] = 8'hFF;
                    default: freq[i] = 8'($urandom_range(1, 16));
                endcase
            write_reg(CFG_MODE, {13'($urandom), 3'(p % 8)});
            write_reg(CFG_MAG_X, mag[0]);
            write_reg(CFG_MAG_Y, mag[1]);
            write_reg(CFG_MAG_Z, mag[2]);
            write_reg(CFG_FREQ_X, {8'($urandom), freq[0]});
            write_reg(CFG_FREQ_Y, {8'($urandom), freq[1]});
            write_reg(CFG_FREQ_Z, {8'($urandom), freq[2]});

            send_idle_pct = (p % 4 == 1) ? 87 : (p % 4 == 3) ? 26 : 0;
            recv_stall_pct = (p % 4 == 2) ? 87 : (p % 4 == 3) ? 26 : 0;

            if (p < 8) begin
                voxel_q.push_back('{12'd0, 12'd0, 12'd0});
                voxel_q.push_back('{12'd4095, 12'd4095, 12'd4095});
                voxel_q.push_back('{12'(p), 12'(p + 3), 12'(3 * p + 5)});
            end
            // Let the output back up so the pipeline fills and stalls its input.
            if (p == 4) stall_start = 1'b1;
            n = 46;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(3) == 0) begin
                    v.x = 12'($urandom_range(11));
                    v.y = 12'($urandom_range(11));
                    v.z = 12'($urandom_range(11));
                end else begin
                    v.x = 12'($urandom);
                    v.y = 12'($urandom);
                    v.z = 12'($urandom);
                end
                voxel_q.push_back(v);
            end
            drain();
        end

        repeat (40) @(posedge aclk);
        if (errors == 0)
            $display("volume_pattern_density_generator: match");
        else
            $display("volume_pattern_density_generator: mismatch");
        $finish;
    end

endmodule
